// ----- design/idai_pkg.sv -----
package idai_pkg;

  // field and state widths
  localparam int SAMPLE_W   = 12;
  localparam int SUM_W      = 20;
  localparam int COUNT_W    = 8;
  localparam int CM_W       = 7;
  localparam int DEN_W      = SAMPLE_W;
  localparam int PROD_W     = SAMPLE_W + CM_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;

  // calibration table geometry
  localparam int TABLE_ENTRIES = 15;
  localparam int TBL_IDX_W     = $clog2(TABLE_ENTRIES);
  localparam int LAST_SEG      = TABLE_ENTRIES - 2;

  // serial unit step counters
  localparam int DIV_STEP_W = $clog2(SUM_W);
  localparam int MUL_STEP_W = $clog2(CM_W);

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(100);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG_DIV,
    ST_SEARCH,
    ST_MUL,
    ST_INT_DIV,
    ST_HOLD
  } state_t;

  // completed average handed to the controller
  typedef struct packed {
    logic               fire;
    logic [SUM_W-1:0]   sum;
    logic [COUNT_W-1:0] divisor;
  } avg_req_t;

  typedef struct packed {
    logic             done;
    logic [SUM_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  // converter level at each calibration point, decreasing
  function automatic logic [SAMPLE_W-1:0] cal_level(input logic [TBL_IDX_W-1:0] idx);
    logic [SAMPLE_W-1:0] lvl;
    case (idx)
      0:       lvl = SAMPLE_W'(3265);
      1:       lvl = SAMPLE_W'(3225);
      2:       lvl = SAMPLE_W'(2920);
      3:       lvl = SAMPLE_W'(2670);
      4:       lvl = SAMPLE_W'(2290);
      5:       lvl = SAMPLE_W'(1950);
      6:       lvl = SAMPLE_W'(1720);
      7:       lvl = SAMPLE_W'(1600);
      8:       lvl = SAMPLE_W'(1445);
      9:       lvl = SAMPLE_W'(1320);
      10:      lvl = SAMPLE_W'(1200);
      11:      lvl = SAMPLE_W'(1100);
      12:      lvl = SAMPLE_W'(1030);
      13:      lvl = SAMPLE_W'(965);
      14:      lvl = SAMPLE_W'(890);
      default: lvl = '0;
    endcase
    return lvl;
  endfunction

  // distance in cm at each calibration point
  function automatic logic [CM_W-1:0] cal_cm(input logic [TBL_IDX_W-1:0] idx);
    logic [CM_W-1:0] cm;
    case (idx)
      0:       cm = CM_W'(10);
      1:       cm = CM_W'(15);
      2:       cm = CM_W'(20);
      3:       cm = CM_W'(25);
      4:       cm = CM_W'(30);
      5:       cm = CM_W'(35);
      6:       cm = CM_W'(40);
      7:       cm = CM_W'(45);
      8:       cm = CM_W'(50);
      9:       cm = CM_W'(55);
      10:      cm = CM_W'(60);
      11:      cm = CM_W'(65);
      12:      cm = CM_W'(70);
      13:      cm = CM_W'(75);
      14:      cm = CM_W'(80);
      default: cm = '0;
    endcase
    return cm;
  endfunction

endpackage

// ----- design/idai_accum.sv -----
module idai_accum (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [idai_pkg::COUNT_W-1:0]  cfg_wdata,
  input  logic                          accept,
  input  logic [idai_pkg::SAMPLE_W-1:0] sample,
  output idai_pkg::avg_req_t            avg_req
);

  logic [idai_pkg::COUNT_W-1:0] avg_count;
  logic [idai_pkg::SUM_W-1:0]   sample_sum;
  logic [idai_pkg::COUNT_W-1:0] samples_taken;

  logic [idai_pkg::SUM_W-1:0]   sum_next;
  logic [idai_pkg::COUNT_W-1:0] taken_next;
  logic [idai_pkg::COUNT_W-1:0] n_eff;

  // running sum and count after this sample, zero count acts as one
  always_comb begin
    sum_next   = sample_sum + idai_pkg::SUM_W'(sample);
    taken_next = samples_taken + idai_pkg::COUNT_W'(1);
    n_eff      = (avg_count == '0) ? idai_pkg::COUNT_W'(1) : avg_count;
    avg_req.fire    = accept && (taken_next >= n_eff);
    avg_req.sum     = sum_next;
    avg_req.divisor = n_eff;
  end

  // count register
  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count <= idai_pkg::COUNT_RESET;
    end else if (cfg_we) begin
      avg_count <= cfg_wdata;
    end
  end

  // accumulator, cleared when an average completes
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
    end else if (accept) begin
      if (avg_req.fire) begin
        sample_sum    <= '0;
        samples_taken <= '0;
      end else begin
        sample_sum    <= sum_next;
        samples_taken <= taken_next;
      end
    end
  end

endmodule

// ----- design/idai_serdiv.sv -----
module idai_serdiv (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [idai_pkg::SUM_W-1:0]   dividend,
  input  logic [idai_pkg::DEN_W-1:0]   divisor,
  output idai_pkg::div_rsp_t           div_rsp
);

  logic                              busy;
  logic                              done;
  logic [idai_pkg::DIV_STEP_W-1:0]   step;
  logic [idai_pkg::SUM_W-1:0]        quo;
  logic [idai_pkg::DEN_W-1:0]        rem;
  logic [idai_pkg::DEN_W-1:0]        dvs;

  logic [idai_pkg::DEN_W:0]          rem_sh;
  logic [idai_pkg::DEN_W:0]          rem_diff;
  logic                              fits;

  // one restoring step: bring down the next dividend bit
  always_comb begin
    rem_sh   = {rem, quo[idai_pkg::SUM_W-1]};
    rem_diff = rem_sh - {1'b0, dvs};
    fits     = rem_sh >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + idai_pkg::DIV_STEP_W'(1);
        if (step == idai_pkg::DIV_STEP_W'(idai_pkg::SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in one bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[idai_pkg::SUM_W-2:0], fits};
      rem <= fits ? rem_diff[idai_pkg::DEN_W-1:0] : rem_sh[idai_pkg::DEN_W-1:0];
    end
  end

  assign div_rsp.done     = done;
  assign div_rsp.quotient = quo;

endmodule

// ----- design/idai_sermul.sv -----
module idai_sermul (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [idai_pkg::SAMPLE_W-1:0] mcand_in,
  input  logic [idai_pkg::CM_W-1:0]     mplier_in,
  output idai_pkg::mul_rsp_t            mul_rsp
);

  logic                            busy;
  logic                            done;
  logic [idai_pkg::MUL_STEP_W-1:0] step;
  logic [idai_pkg::PROD_W-1:0]     acc;
  logic [idai_pkg::PROD_W-1:0]     mcand;
  logic [idai_pkg::CM_W-1:0]       mplier;

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + idai_pkg::MUL_STEP_W'(1);
        if (step == idai_pkg::MUL_STEP_W'(idai_pkg::CM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // shift-add, one multiplier bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= idai_pkg::PROD_W'(mcand_in);
      mplier <= mplier_in;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[idai_pkg::PROD_W-2:0], 1'b0};
      mplier <= {1'b0, mplier[idai_pkg::CM_W-1:1]};
    end
  end

  assign mul_rsp.done    = done;
  assign mul_rsp.product = acc;

endmodule

// ----- design/ir_distance_average_interpolate_unit.sv -----
// Averaging infrared range converter. Each transaction on the s_ side carries
// one 12-bit sensor reading; after average_count readings (cfg_wdata, reset
// 100, zero acts as one) one result leaves on the m_ side with the floor of
// the mean, the distance in cm interpolated in a 15-point calibration table,
// and tuser set when the mean lies outside the table (distance then 0).
// A reading that does not complete an average is only added to the running sum. The reading
// that completes one starts a serial pass: a bit-serial divider forms the
// mean, the table is searched one segment a cycle (up to 14 segments), a
// shift-add multiplier forms the product, the shared divider divides it and
// the output register takes the result once it is free. s_tready stays low
// during that pass; a finished result waits in the output register without
// blocking new readings once it has been handed over.
module ir_distance_average_interpolate_unit (
  input  logic                            clk,
  input  logic                            rst,
  // average_count
  input  logic                            cfg_we,
  input  logic [idai_pkg::COUNT_W-1:0]    cfg_wdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // [11:0] sample
  input  logic [idai_pkg::IN_DATA_W-1:0]  s_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [6:0] distance_cm, [18:7] average_sample
  output logic [idai_pkg::OUT_DATA_W-1:0] m_tdata,
  // [0] out_of_range
  output logic                            m_tuser
);

  idai_pkg::state_t state;
  idai_pkg::state_t state_next;

  idai_pkg::avg_req_t avg_req;
  idai_pkg::div_rsp_t div_rsp;
  idai_pkg::mul_rsp_t mul_rsp;

  logic [idai_pkg::SAMPLE_W-1:0]  mean;
  logic [idai_pkg::TBL_IDX_W-1:0] seg_idx;
  logic [idai_pkg::DEN_W-1:0]     den;
  logic [idai_pkg::CM_W-1:0]      res_cm;
  logic                           res_oor;

  logic                           in_accept;
  logic                           out_load;
  logic                           div_start;
  logic [idai_pkg::SUM_W-1:0]     div_dividend;
  logic [idai_pkg::DEN_W-1:0]     div_divisor;
  logic                           mul_start;
  logic [idai_pkg::SAMPLE_W-1:0]  y1;
  logic [idai_pkg::SAMPLE_W-1:0]  y2;
  logic [idai_pkg::CM_W-1:0]      x1;
  logic [idai_pkg::CM_W-1:0]      x2;
  logic [idai_pkg::CM_W-1:0]      span;
  logic                           seg_hit;
  logic                           seg_last;
  logic [idai_pkg::SAMPLE_W-1:0]  mean_sat;

  assign in_accept = s_tvalid && s_tready;

  idai_accum u_accum (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .accept    (in_accept),
    .sample    (s_tdata[idai_pkg::SAMPLE_W-1:0]),
    .avg_req   (avg_req)
  );

  idai_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .div_rsp  (div_rsp)
  );

  idai_sermul u_mul (
    .clk       (clk),
    .rst       (rst),
    .start     (mul_start),
    .mcand_in  (y1 - mean),
    .mplier_in (span),
    .mul_rsp   (mul_rsp)
  );

  // current table segment
  always_comb begin
    y1       = idai_pkg::cal_level(seg_idx);
    y2       = idai_pkg::cal_level(seg_idx + idai_pkg::TBL_IDX_W'(1));
    x1       = idai_pkg::cal_cm(seg_idx);
    x2       = idai_pkg::cal_cm(seg_idx + idai_pkg::TBL_IDX_W'(1));
    span     = (x2 >= x1) ? (x2 - x1) : '0;
    seg_hit  = (y1 >= mean) && (y2 < mean);
    seg_last = seg_idx == idai_pkg::TBL_IDX_W'(idai_pkg::LAST_SEG);
    mean_sat = (div_rsp.quotient[idai_pkg::SUM_W-1:idai_pkg::SAMPLE_W] != '0) ?
               '1 : div_rsp.quotient[idai_pkg::SAMPLE_W-1:0];
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= idai_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and unit strobes
  always_comb begin
    state_next   = state;
    s_tready     = 1'b0;
    out_load     = 1'b0;
    div_start    = 1'b0;
    div_dividend = avg_req.sum;
    div_divisor  = idai_pkg::DEN_W'(avg_req.divisor);
    mul_start    = 1'b0;
    case (state)
      idai_pkg::ST_IDLE: begin
        s_tready = 1'b1;
        if (avg_req.fire) begin
          div_start  = 1'b1;
          state_next = idai_pkg::ST_AVG_DIV;
        end
      end
      idai_pkg::ST_AVG_DIV: begin
        if (div_rsp.done) begin
          state_next = idai_pkg::ST_SEARCH;
        end
      end
      idai_pkg::ST_SEARCH: begin
        if (seg_hit) begin
          mul_start  = 1'b1;
          state_next = idai_pkg::ST_MUL;
        end else if (seg_last) begin
          state_next = idai_pkg::ST_HOLD;
        end
      end
      idai_pkg::ST_MUL: begin
        div_dividend = idai_pkg::SUM_W'(mul_rsp.product);
        div_divisor  = den;
        if (mul_rsp.done) begin
          div_start  = 1'b1;
          state_next = idai_pkg::ST_INT_DIV;
        end
      end
      idai_pkg::ST_INT_DIV: begin
        if (div_rsp.done) begin
          state_next = idai_pkg::ST_HOLD;
        end
      end
      idai_pkg::ST_HOLD: begin
        if (!m_tvalid || m_tready) begin
          out_load   = 1'b1;
          state_next = idai_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = idai_pkg::ST_IDLE;
      end
    endcase
  end

  // working registers of the interpolation pass
  always_ff @(posedge clk) begin
    if (state == idai_pkg::ST_AVG_DIV && div_rsp.done) begin
      mean    <= mean_sat;
      seg_idx <= '0;
    end
    if (state == idai_pkg::ST_SEARCH) begin
      if (seg_hit) begin
        den <= y1 - y2;
      end else if (seg_last) begin
        res_cm  <= '0;
        res_oor <= 1'b1;
      end else begin
        seg_idx <= seg_idx + idai_pkg::TBL_IDX_W'(1);
      end
    end
    if (state == idai_pkg::ST_INT_DIV && div_rsp.done) begin
      res_cm  <= x1 + div_rsp.quotient[idai_pkg::CM_W-1:0];
      res_oor <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= idai_pkg::OUT_DATA_W'({mean, res_cm});
      m_tuser <= res_oor;
    end
  end

`ifndef SYNTH
  // an out-of-range result never carries a distance
  a_oor_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tdata[idai_pkg::CM_W-1:0] == '0))
    else $error("out-of-range result with nonzero distance");

  // an in-range distance stays within the table span
  a_cm_span: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser) |->
      (m_tdata[idai_pkg::CM_W-1:0] >= idai_pkg::cal_cm('0)) &&
      (m_tdata[idai_pkg::CM_W-1:0] <=
        idai_pkg::cal_cm(idai_pkg::TBL_IDX_W'(idai_pkg::TABLE_ENTRIES - 1))))
    else $error("distance outside calibration span");

  // the shared divider only finishes while a division is awaited
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == idai_pkg::ST_AVG_DIV || state == idai_pkg::ST_INT_DIV))
    else $error("divider finished outside a division state");

  // segment search never runs past the last segment
  a_seg_bound: assert property (@(posedge clk) disable iff (rst)
    (state == idai_pkg::ST_SEARCH) |->
      (seg_idx <= idai_pkg::TBL_IDX_W'(idai_pkg::LAST_SEG)))
    else $error("segment index past table end");

  // the multiplier hands over right before the second division
  a_mul_div: assert property (@(posedge clk) disable iff (rst)
    (state == idai_pkg::ST_MUL && mul_rsp.done) |=> (state == idai_pkg::ST_INT_DIV))
    else $error("interpolation division not started after product");
`endif

endmodule
